// ===== rtl/core/gfc_pkg.sv =====
package gfc_pkg;

	localparam int CANVAS_MAX_W = 256;
	localparam int CANVAS_MAX_H = 256;
	localparam int PALETTE_DEPTH = 256;

	localparam int XW = (CANVAS_MAX_W > 1) ? $clog2(CANVAS_MAX_W) : 1;
	localparam int YW = (CANVAS_MAX_H > 1) ? $clog2(CANVAS_MAX_H) : 1;
	localparam int EW = $clog2(CANVAS_MAX_W + 1);
	localparam int EH = $clog2(CANVAS_MAX_H + 1);
	localparam int CANVAS_DEPTH = CANVAS_MAX_W * CANVAS_MAX_H;
	localparam int AW = (CANVAS_DEPTH > 1) ? $clog2(CANVAS_DEPTH) : 1;
	localparam int PAW = $clog2(PALETTE_DEPTH);
	localparam int MW = YW + EW + 1;

	localparam int IQ_DEPTH = 2;
	localparam int IQW = $clog2(IQ_DEPTH);
	localparam int IQCW = $clog2(IQ_DEPTH + 1);
	localparam int RQ_DEPTH = 4;
	localparam int RQW = $clog2(RQ_DEPTH);
	localparam int RQCW = $clog2(RQ_DEPTH + 1);

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [2:0] DISP_BACKGROUND = 3'd2;
	localparam logic [2:0] DISP_PREVIOUS = 3'd3;

	typedef enum logic [1:0] {
		REQ_PALETTE = 2'd0,
		REQ_FRAME   = 2'd1,
		REQ_PIXEL   = 2'd2,
		REQ_READ    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BG     = 2'd2,
		CFG_GMAP   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SQ_RUN,
		SQ_ERASE,
		SQ_FILL,
		SQ_COPY
	} seq_state_t;

	typedef struct packed {
		req_kind_t   kind;
		logic        slot_ok;
		logic [7:0]  color_index;
		logic [23:0] color_rgb;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
		logic        trans;
		logic [2:0]  disposal;
		logic        first;
		logic        last;
		logic        pal_ok;
	} item_t;

	typedef struct packed {
		logic [31:0] argb;
		logic        valid;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t data;
	} res_beat_t;

	function automatic logic [EW-1:0] eff_width(input logic [8:0] v);
		if (v == 9'd0) return EW'(1);
		if (32'(v) > CANVAS_MAX_W) return EW'(CANVAS_MAX_W);
		return EW'(v);
	endfunction

	function automatic logic [EH-1:0] eff_height(input logic [8:0] v);
		if (v == 9'd0) return EH'(1);
		if (32'(v) > CANVAS_MAX_H) return EH'(CANVAS_MAX_H);
		return EH'(v);
	endfunction

	function automatic logic [AW-1:0] canvas_addr(input logic [YW-1:0] y,
		input logic [XW-1:0] x, input logic [EW-1:0] w);
		logic [MW-1:0] p;
		p = MW'(y) * MW'(w);
		p = p + MW'(x);
		return p[AW-1:0];
	endfunction

endpackage

// ===== rtl/core/gfc_ram.sv =====
module gfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/gfc_front.sv =====
module gfc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          req_type,
	input  logic [7:0]          color_index,
	input  logic [23:0]         color_rgb,
	input  logic [15:0]         frame_left,
	input  logic [15:0]         frame_top,
	input  logic [15:0]         frame_width,
	input  logic [15:0]         frame_height,
	input  logic                transparent_flag,
	input  logic [2:0]          disposal,
	input  logic                first_frame,
	input  logic                last_frame,
	input  logic                palette_valid,
	output logic                head_valid,
	output gfc_pkg::item_t      head,
	input  logic                take
);

	gfc_pkg::item_t            mem_q [gfc_pkg::IQ_DEPTH];
	gfc_pkg::item_t            item;
	logic [gfc_pkg::IQW-1:0]   wp_q, rp_q;
	logic [gfc_pkg::IQCW-1:0]  cnt_q;
	logic                      do_push, do_pop;

	always_comb begin
		item.kind        = gfc_pkg::req_kind_t'(req_type);
		item.slot_ok     = 32'(color_index) < gfc_pkg::PALETTE_DEPTH;
		item.color_index = color_index;
		item.color_rgb   = color_rgb;
		item.left        = frame_left;
		item.top         = frame_top;
		item.width       = frame_width;
		item.height      = frame_height;
		item.trans       = transparent_flag;
		item.disposal    = disposal;
		item.first       = first_frame;
		item.last        = last_frame;
		item.pal_ok      = palette_valid;
	end

	assign full       = cnt_q == gfc_pkg::IQCW'(gfc_pkg::IQ_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = take && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == gfc_pkg::IQW'(gfc_pkg::IQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == gfc_pkg::IQW'(gfc_pkg::IQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gfc_back.sv =====
module gfc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [1:0]               cfg_index,
	input  logic [23:0]              cfg_data,
	input  logic                     head_valid,
	input  gfc_pkg::item_t           head,
	output logic                     take,
	input  logic [gfc_pkg::RQCW-1:0] rq_count,
	output gfc_pkg::res_beat_t       res
);

	localparam int AW = gfc_pkg::AW;
	localparam int XW = gfc_pkg::XW;
	localparam int YW = gfc_pkg::YW;
	localparam int EW = gfc_pkg::EW;
	localparam int EH = gfc_pkg::EH;

	gfc_pkg::seq_state_t state_q, state_d;

	logic          bank_q;
	logic [EW-1:0] w_q;
	logic [EH-1:0] h_q;
	logic [23:0]   bg_q;
	logic          gmp_q;
	logic [31:0]   paint_q;

	logic [15:0]   pl_q, pt_q, pw_q, ph_q;
	logic [2:0]    pdisp_q;
	logic [15:0]   cl_q, ct_q, cw_q, ch_q;
	logic          ctrans_q, cdraw_q;
	logic [7:0]    ctidx_q;
	logic [15:0]   rx_q, ry_q;

	logic [XW-1:0] wx_q, wxs_q;
	logic [YW-1:0] wy_q;
	logic [EW-1:0] wxe_q;
	logic [EH-1:0] wye_q;
	logic          copy_pend_q;
	logic          cpy_v_q;
	logic [AW-1:0] cpy_addr_q;

	logic          v_s2, wr_s2, rd_s2, inr_s2, palok_s2;
	logic [AW-1:0] addr_s2;

	logic          room, issue, fs;
	logic [16:0]   ple, pte, nle, nte, fxe, fye;
	logic          covers, prev_act, do_dispose, do_fill, do_swap, fill_ne;
	logic [31:0]   new_paint;
	logic [EW:0]   wx_inc;
	logic [EH:0]   wy_inc;
	logic          row_end, walk_last;
	logic [AW-1:0] walk_addr, rd_addr, pix_addr;
	logic          inr;
	logic          pix_act, pix_wr;
	logic [16:0]   cx, cy, rx_inc;
	logic          st_erase, st_fill, st_copy;

	logic          bank_we [2];
	logic [AW-1:0] bank_waddr [2];
	logic [31:0]   bank_wdata [2];
	logic [AW-1:0] bank_raddr;
	logic [31:0]   bank_rdata [2];
	logic [31:0]   front_rdata;
	logic [23:0]   pal_rdata;
	logic          pal_we;

	assign room = ((gfc_pkg::RQCW + 1)'(rq_count) + (gfc_pkg::RQCW + 1)'(v_s2))
		< (gfc_pkg::RQCW + 1)'(gfc_pkg::RQ_DEPTH);
	// A read is held back while a pixel write sits in the s2 register so it never sees stale bank data.
	assign issue = head_valid && state_q == gfc_pkg::SQ_RUN && !cpy_v_q && room &&
		!(head.kind == gfc_pkg::REQ_READ && wr_s2);
	assign take = issue;
	assign fs = issue && head.kind == gfc_pkg::REQ_FRAME;

	always_comb begin
		ple = 17'(pl_q) + 17'(pw_q);
		pte = 17'(pt_q) + 17'(ph_q);
		nle = 17'(head.left) + 17'(head.width);
		nte = 17'(head.top) + 17'(head.height);
		covers = head.left <= pl_q && ple <= nle && head.top <= pt_q && pte <= nte;
		prev_act = pdisp_q == gfc_pkg::DISP_BACKGROUND || pdisp_q == gfc_pkg::DISP_PREVIOUS;
		do_dispose = prev_act && (head.trans || !covers);
		fxe = (ple > 17'(w_q)) ? 17'(w_q) : ple;
		fye = (pte > 17'(h_q)) ? 17'(h_q) : pte;
		fill_ne = 17'(pl_q) < fxe && 17'(pt_q) < fye;
		do_fill = do_dispose && pdisp_q == gfc_pkg::DISP_BACKGROUND && fill_ne;
		do_swap = do_dispose && pdisp_q == gfc_pkg::DISP_PREVIOUS;
		new_paint = (!head.trans && gmp_q) ? {gfc_pkg::ALPHA_OPAQUE, bg_q} : paint_q;
	end

	always_comb begin
		wx_inc = (EW + 1)'(wx_q) + 1'b1;
		wy_inc = (EH + 1)'(wy_q) + 1'b1;
		row_end = wx_inc == (EW + 1)'(wxe_q);
		walk_last = row_end && wy_inc == (EH + 1)'(wye_q);
		walk_addr = gfc_pkg::canvas_addr(wy_q, wx_q, w_q);
	end

	always_comb begin
		inr = 17'(head.left) < 17'(w_q) && 17'(head.top) < 17'(h_q);
		rd_addr = gfc_pkg::canvas_addr(head.top[YW-1:0], head.left[XW-1:0], w_q);
		pix_act = rx_q < cw_q && ry_q < ch_q;
		cx = 17'(cl_q) + 17'(rx_q);
		cy = 17'(ct_q) + 17'(ry_q);
		pix_wr = pix_act && cdraw_q && cx < 17'(w_q) && cy < 17'(h_q) &&
			!(ctrans_q && head.color_index == ctidx_q);
		pix_addr = gfc_pkg::canvas_addr(cy[YW-1:0], cx[XW-1:0], w_q);
		rx_inc = 17'(rx_q) + 17'd1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gfc_pkg::SQ_RUN: begin
				if (fs) begin
					if (head.first) begin
						state_d = gfc_pkg::SQ_ERASE;
					end else if (do_fill) begin
						state_d = gfc_pkg::SQ_FILL;
					end else if (head.disposal == gfc_pkg::DISP_PREVIOUS) begin
						state_d = gfc_pkg::SQ_COPY;
					end
				end
			end
			gfc_pkg::SQ_ERASE: begin
				if (walk_last) state_d = gfc_pkg::SQ_RUN;
			end
			gfc_pkg::SQ_FILL: begin
				if (walk_last) state_d = copy_pend_q ? gfc_pkg::SQ_COPY : gfc_pkg::SQ_RUN;
			end
			gfc_pkg::SQ_COPY: begin
				if (walk_last) state_d = gfc_pkg::SQ_RUN;
			end
			default: state_d = gfc_pkg::SQ_RUN;
		endcase
	end

	always_comb begin
		st_erase = 1'b0;
		st_fill  = 1'b0;
		st_copy  = 1'b0;
		case (state_q)
			gfc_pkg::SQ_ERASE: st_erase = 1'b1;
			gfc_pkg::SQ_FILL:  st_fill  = 1'b1;
			gfc_pkg::SQ_COPY:  st_copy  = 1'b1;
			default: ;
		endcase
	end

	assign front_rdata = bank_q ? bank_rdata[1] : bank_rdata[0];
	assign bank_raddr  = st_copy ? walk_addr : rd_addr;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			if (st_erase) begin
				bank_we[b]    = 1'b1;
				bank_waddr[b] = walk_addr;
				bank_wdata[b] = paint_q;
			end else if (st_fill) begin
				bank_we[b]    = bank_q == 1'(b);
				bank_waddr[b] = walk_addr;
				bank_wdata[b] = paint_q;
			end else if (cpy_v_q) begin
				bank_we[b]    = bank_q != 1'(b);
				bank_waddr[b] = cpy_addr_q;
				bank_wdata[b] = front_rdata;
			end else begin
				bank_we[b]    = wr_s2 && bank_q == 1'(b);
				bank_waddr[b] = addr_s2;
				bank_wdata[b] = {gfc_pkg::ALPHA_OPAQUE, palok_s2 ? pal_rdata : 24'd0};
			end
		end
	end

	gfc_ram #(.WIDTH(32), .DEPTH(gfc_pkg::CANVAS_DEPTH)) u_bank_a (
		.clk(clk), .we(bank_we[0]), .waddr(bank_waddr[0]), .wdata(bank_wdata[0]),
		.raddr(bank_raddr), .rdata(bank_rdata[0])
	);

	gfc_ram #(.WIDTH(32), .DEPTH(gfc_pkg::CANVAS_DEPTH)) u_bank_b (
		.clk(clk), .we(bank_we[1]), .waddr(bank_waddr[1]), .wdata(bank_wdata[1]),
		.raddr(bank_raddr), .rdata(bank_rdata[1])
	);

	assign pal_we = issue && head.kind == gfc_pkg::REQ_PALETTE && head.slot_ok;

	gfc_ram #(.WIDTH(24), .DEPTH(gfc_pkg::PALETTE_DEPTH)) u_palette (
		.clk(clk), .we(pal_we), .waddr(head.color_index[gfc_pkg::PAW-1:0]),
		.wdata(head.color_rgb), .raddr(head.color_index[gfc_pkg::PAW-1:0]),
		.rdata(pal_rdata)
	);

	always_comb begin
		res.push       = v_s2;
		res.data.valid = rd_s2;
		res.data.argb  = (rd_s2 && inr_s2) ? front_rdata : 32'd0;
	end

	always_ff @(posedge clk) begin
		addr_s2    <= (head.kind == gfc_pkg::REQ_READ) ? rd_addr : pix_addr;
		inr_s2     <= inr;
		palok_s2   <= head.slot_ok;
		cpy_addr_q <= walk_addr;
		if (fs) begin
			if (!head.first && do_fill) begin
				wx_q  <= pl_q[XW-1:0];
				wxs_q <= pl_q[XW-1:0];
				wy_q  <= pt_q[YW-1:0];
				wxe_q <= fxe[EW-1:0];
				wye_q <= fye[EH-1:0];
			end else begin
				wx_q  <= '0;
				wxs_q <= '0;
				wy_q  <= '0;
				wxe_q <= w_q;
				wye_q <= h_q;
			end
		end else if (st_erase || st_fill || st_copy) begin
			if (walk_last) begin
				// A fill that is followed by a save restarts the walk on the whole canvas.
				wx_q  <= '0;
				wxs_q <= '0;
				wy_q  <= '0;
				wxe_q <= w_q;
				wye_q <= h_q;
			end else if (row_end) begin
				wx_q <= wxs_q;
				wy_q <= wy_inc[YW-1:0];
			end else begin
				wx_q <= wx_inc[XW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfc_pkg::SQ_RUN;
			bank_q      <= 1'b0;
			w_q         <= gfc_pkg::eff_width(9'd256);
			h_q         <= gfc_pkg::eff_height(9'd256);
			bg_q        <= '0;
			gmp_q       <= 1'b0;
			paint_q     <= '0;
			pl_q        <= '0;
			pt_q        <= '0;
			pw_q        <= '0;
			ph_q        <= '0;
			pdisp_q     <= '0;
			cl_q        <= '0;
			ct_q        <= '0;
			cw_q        <= '0;
			ch_q        <= '0;
			ctrans_q    <= 1'b0;
			ctidx_q     <= '0;
			cdraw_q     <= 1'b0;
			rx_q        <= '0;
			ry_q        <= '0;
			copy_pend_q <= 1'b0;
			cpy_v_q     <= 1'b0;
			v_s2        <= 1'b0;
			wr_s2       <= 1'b0;
			rd_s2       <= 1'b0;
		end else begin
			state_q <= state_d;
			cpy_v_q <= st_copy;
			v_s2    <= issue;
			wr_s2   <= issue && head.kind == gfc_pkg::REQ_PIXEL && pix_wr;
			rd_s2   <= issue && head.kind == gfc_pkg::REQ_READ;
			if (cfg_valid) begin
				case (gfc_pkg::cfg_reg_t'(cfg_index))
					gfc_pkg::CFG_WIDTH:  w_q   <= gfc_pkg::eff_width(cfg_data[8:0]);
					gfc_pkg::CFG_HEIGHT: h_q   <= gfc_pkg::eff_height(cfg_data[8:0]);
					gfc_pkg::CFG_BG:     bg_q  <= cfg_data;
					gfc_pkg::CFG_GMAP:   gmp_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (fs) begin
				if (head.first) begin
					paint_q <= new_paint;
				end else if (do_swap) begin
					bank_q <= !bank_q;
				end
				copy_pend_q <= head.disposal == gfc_pkg::DISP_PREVIOUS;
				pl_q     <= head.left;
				pt_q     <= head.top;
				pw_q     <= head.width;
				ph_q     <= head.height;
				pdisp_q  <= head.disposal;
				cl_q     <= head.left;
				ct_q     <= head.top;
				cw_q     <= head.width;
				ch_q     <= head.height;
				ctrans_q <= head.trans;
				ctidx_q  <= head.color_index;
				cdraw_q  <= head.pal_ok && (head.last ||
					!(head.disposal == gfc_pkg::DISP_BACKGROUND ||
					head.disposal == gfc_pkg::DISP_PREVIOUS));
				rx_q     <= '0;
				ry_q     <= '0;
			end else if (issue && head.kind == gfc_pkg::REQ_PIXEL && pix_act) begin
				if (rx_inc >= 17'(cw_q)) begin
					rx_q <= '0;
					ry_q <= ry_q + 16'd1;
				end else begin
					rx_q <= rx_inc[15:0];
				end
			end
		end
	end

endmodule

// ===== rtl/core/gfc_resq.sv =====
module gfc_resq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gfc_pkg::res_beat_t       res,
	input  logic                     pop,
	output logic                     empty,
	output gfc_pkg::result_t         head,
	output logic [gfc_pkg::RQCW-1:0] count
);

	gfc_pkg::result_t          mem_q [gfc_pkg::RQ_DEPTH];
	logic [gfc_pkg::RQW-1:0]   wp_q, rp_q;
	logic [gfc_pkg::RQCW-1:0]  cnt_q;
	logic                      do_pop;

	assign empty  = cnt_q == '0;
	assign head   = mem_q[rp_q];
	assign count  = cnt_q;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (res.push) begin
			mem_q[wp_q] <= res.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res.push) begin
				wp_q <= (wp_q == gfc_pkg::RQW'(gfc_pkg::RQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == gfc_pkg::RQW'(gfc_pkg::RQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (res.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!res.push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gif_frame_compositor.sv =====
// Channel   Direction  Handshake             Beat
// input     in         push / full           one request item
// result    out        pop / empty           pixel_argb, pixel_valid
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Palette, pixel and read items pass the registered s2 stage of the back end; a
// read right after a written pixel is held until that write is done.
// A frame start may sweep the canvas: on the first frame both banks are erased
// in the same sweep, a background fill covers the clipped previous rectangle,
// and a save copies the whole canvas, one pixel per cycle of the bank ports.
// Reset clears all control state; canvas and palette contents are not cleared.
// The input stalls while the result queue is full or a canvas sweep runs.
module gif_frame_compositor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  color_index,
	input  logic [23:0] color_rgb,
	input  logic [15:0] frame_left,
	input  logic [15:0] frame_top,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic        transparent_flag,
	input  logic [2:0]  disposal,
	input  logic        first_frame,
	input  logic        last_frame,
	input  logic        palette_valid,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] pixel_argb,
	output logic        pixel_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	gfc_pkg::item_t                head;
	logic                          head_valid, take;
	gfc_pkg::res_beat_t            res;
	gfc_pkg::result_t              rq_head;
	logic [gfc_pkg::RQCW-1:0]      rq_count;

	assign cfg_ready = 1'b1;

	gfc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .color_index(color_index), .color_rgb(color_rgb),
		.frame_left(frame_left), .frame_top(frame_top), .frame_width(frame_width),
		.frame_height(frame_height), .transparent_flag(transparent_flag),
		.disposal(disposal), .first_frame(first_frame), .last_frame(last_frame),
		.palette_valid(palette_valid), .head_valid(head_valid), .head(head),
		.take(take)
	);

	gfc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .head_valid(head_valid), .head(head), .take(take),
		.rq_count(rq_count), .res(res)
	);

	gfc_resq u_resq (
		.clk(clk), .arst_n(arst_n), .res(res), .pop(pop), .empty(empty),
		.head(rq_head), .count(rq_count)
	);

	assign pixel_argb  = rq_head.argb;
	assign pixel_valid = rq_head.valid;

endmodule

// ===== rtl/core/gfc_checker.sv =====
module gfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [1:0]  req_type,
	input logic [7:0]  color_index,
	input logic [23:0] color_rgb,
	input logic [15:0] frame_left,
	input logic [15:0] frame_top,
	input logic [15:0] frame_width,
	input logic [15:0] frame_height,
	input logic        transparent_flag,
	input logic [2:0]  disposal,
	input logic        first_frame,
	input logic        last_frame,
	input logic        palette_valid,
	input logic        empty,
	input logic        pop,
	input logic [31:0] pixel_argb,
	input logic        pixel_valid,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [23:0] cfg_data
);

	// Only read answers carry pixel data.
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pixel_valid |-> pixel_argb == 32'd0)
		else $error("non-read result carries pixel data");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	// No result can exist in the first cycle after reset ends.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_argb) && $stable(pixel_valid))
		else $error("waiting result changed");

endmodule

bind gif_frame_compositor gfc_checker u_gfc_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;

	typedef struct {
		gfc_pkg::req_kind_t kind;
		logic [7:0]  idx;
		logic [23:0] rgb;
		logic [15:0] l, t, w, h;
		logic        trans;
		logic [2:0]  disp;
		logic        first, last, palok;
	} req_t;

	typedef struct {
		logic [31:0] argb;
		logic        valid;
	} pix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  req_type = '0;
	logic [7:0]  color_index = '0;
	logic [23:0] color_rgb = '0;
	logic [15:0] frame_left = '0, frame_top = '0, frame_width = '0, frame_height = '0;
	logic        transparent_flag = 1'b0;
	logic [2:0]  disposal = '0;
	logic        first_frame = 1'b0, last_frame = 1'b0, palette_valid = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] pixel_argb;
	logic        pixel_valid;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	gif_frame_compositor DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state.
	bit [31:0]   canvas [2][gfc_pkg::CANVAS_DEPTH];
	bit          sel;
	bit [23:0]   palette [gfc_pkg::PALETTE_DEPTH];
	int unsigned prv_l, prv_t, prv_w, prv_h;
	bit [2:0]    prv_disp;
	bit [31:0]   paint;
	int unsigned ras_x, ras_y;
	int unsigned cur_l, cur_t, cur_w, cur_h;
	bit          cur_trans, cur_draw;
	bit [7:0]    cur_tidx;
	bit [8:0]    reg_w = 9'd256, reg_h = 9'd256;
	bit [23:0]   reg_bg;
	bit          reg_gmap;

	pix_t pending_pix [$];
	int   fails = 0;
	int   n_sent = 0;
	bit   calm = 0;
	bit   hold_rx = 0;
	int   tx_gap = 0;

	function automatic int unsigned canvas_w();
		if (reg_w == 9'd0) return 1;
		return (32'(reg_w) > gfc_pkg::CANVAS_MAX_W) ? gfc_pkg::CANVAS_MAX_W : 32'(reg_w);
	endfunction

	function automatic int unsigned canvas_h();
		if (reg_h == 9'd0) return 1;
		return (32'(reg_h) > gfc_pkg::CANVAS_MAX_H) ? gfc_pkg::CANVAS_MAX_H : 32'(reg_h);
	endfunction

	function automatic void fill_rect(bit b, int unsigned l, int unsigned t,
		int unsigned w, int unsigned h, bit [31:0] c);
		int unsigned cw, ch, xe, ye;
		cw = canvas_w();
		ch = canvas_h();
		xe = (l + w > cw) ? cw : l + w;
		ye = (t + h > ch) ? ch : t + h;
		for (int unsigned y = t; y < ye; y++)
			for (int unsigned x = l; x < xe; x++)
				canvas[b][y * cw + x] = c;
	endfunction

	function automatic void predict_composite(req_t r);
		pix_t        p;
		int unsigned cw, ch, cx, cy, n;
		bit          covers;
		cw = canvas_w();
		ch = canvas_h();
		p.argb = '0;
		p.valid = 1'b0;
		case (r.kind)
			gfc_pkg::REQ_PALETTE: palette[r.idx] = r.rgb;
			gfc_pkg::REQ_FRAME: begin
				if (r.first) begin
					if (!r.trans && reg_gmap) paint = {gfc_pkg::ALPHA_OPAQUE, reg_bg};
					fill_rect(1'b0, 0, 0, cw, ch, paint);
					fill_rect(1'b1, 0, 0, cw, ch, paint);
				end else begin
					covers = r.l <= prv_l && prv_l + prv_w <= 32'(r.l) + 32'(r.w) &&
						r.t <= prv_t && prv_t + prv_h <= 32'(r.t) + 32'(r.h);
					if ((prv_disp == gfc_pkg::DISP_BACKGROUND ||
						prv_disp == gfc_pkg::DISP_PREVIOUS) && (r.trans || !covers)) begin
						if (prv_disp == gfc_pkg::DISP_BACKGROUND)
							fill_rect(sel, prv_l, prv_t, prv_w, prv_h, paint);
						else
							sel = ~sel;
					end
					if (r.disp == gfc_pkg::DISP_PREVIOUS) begin
						n = cw * ch;
						for (int unsigned i = 0; i < n; i++) canvas[~sel][i] = canvas[sel][i];
					end
				end
				prv_l = r.l; prv_t = r.t; prv_w = r.w; prv_h = r.h; prv_disp = r.disp;
				cur_l = r.l; cur_t = r.t; cur_w = r.w; cur_h = r.h;
				cur_trans = r.trans;
				cur_tidx = r.idx;
				cur_draw = r.palok && (r.last || !(r.disp == gfc_pkg::DISP_BACKGROUND ||
					r.disp == gfc_pkg::DISP_PREVIOUS));
				ras_x = 0;
				ras_y = 0;
			end
			gfc_pkg::REQ_PIXEL: begin
				if (ras_x < cur_w && ras_y < cur_h) begin
					cx = cur_l + ras_x;
					cy = cur_t + ras_y;
					if (cur_draw && cx < cw && cy < ch && !(cur_trans && r.idx == cur_tidx))
						canvas[sel][cy * cw + cx] = {gfc_pkg::ALPHA_OPAQUE, palette[r.idx]};
					ras_x++;
					if (ras_x >= cur_w) begin
						ras_x = 0;
						ras_y++;
					end
				end
			end
			default: begin
				if (r.l < cw && r.t < ch) p.argb = canvas[sel][32'(r.t) * cw + 32'(r.l)];
				p.valid = 1'b1;
			end
		endcase
		pending_pix.push_back(p);
	endfunction

	// Sender: one beat per call; push stays high when the next beat follows at once.
	task automatic send(req_t r);
		push <= 1'b1;
		req_type <= r.kind;
		color_index <= r.idx;
		color_rgb <= r.rgb;
		frame_left <= r.l;
		frame_top <= r.t;
		frame_width <= r.w;
		frame_height <= r.h;
		transparent_flag <= r.trans;
		disposal <= r.disp;
		first_frame <= r.first;
		last_frame <= r.last;
		palette_valid <= r.palok;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_composite(r);
		n_sent++;
		if (!calm && tx_gap == 0 && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 4);
		if (tx_gap > 0) begin
			push <= 1'b0;
			repeat (tx_gap) @(posedge clk);
			tx_gap = 0;
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(gfc_pkg::cfg_reg_t idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			gfc_pkg::CFG_WIDTH:  reg_w = val[8:0];
			gfc_pkg::CFG_HEIGHT: reg_h = val[8:0];
			gfc_pkg::CFG_BG:     reg_bg = val;
			default:             reg_gmap = val[0];
		endcase
	endtask

	function automatic req_t mk(gfc_pkg::req_kind_t k);
		req_t r;
		r.kind = k;
		r.idx = 8'($urandom_range(0, 255));
		r.rgb = 24'($urandom_range(0, 24'hFFFFFF));
		r.l = 16'($urandom_range(0, 65535));
		r.t = 16'($urandom_range(0, 65535));
		r.w = 16'($urandom_range(0, 65535));
		r.h = 16'($urandom_range(0, 65535));
		r.trans = 1'($urandom_range(0, 1));
		r.disp = 3'($urandom_range(0, 7));
		r.first = 1'($urandom_range(0, 1));
		r.last = 1'($urandom_range(0, 1));
		r.palok = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t mk_frame(int unsigned l, int unsigned t, int unsigned w,
		int unsigned h, bit trans, bit [7:0] tidx, bit [2:0] disp, bit first, bit last,
		bit palok);
		req_t r;
		r = mk(gfc_pkg::REQ_FRAME);
		r.l = 16'(l); r.t = 16'(t); r.w = 16'(w); r.h = 16'(h);
		r.trans = trans; r.idx = tidx; r.disp = disp;
		r.first = first; r.last = last; r.palok = palok;
		return r;
	endfunction

	task automatic send_read(int unsigned x, int unsigned y);
		req_t r;
		r = mk(gfc_pkg::REQ_READ);
		r.l = 16'(x);
		r.t = 16'(y);
		send(r);
	endtask

	task automatic send_raster(int n);
		req_t r;
		for (int i = 0; i < n; i++) begin
			r = mk(gfc_pkg::REQ_PIXEL);
			if ($urandom_range(0, 3) == 0) r.idx = cur_tidx;
			send(r);
		end
	endtask

	task automatic set_canvas(logic [8:0] w, logic [8:0] h, logic [23:0] bg, bit gmap);
		drain();
		write_reg(gfc_pkg::CFG_WIDTH, 24'(w));
		write_reg(gfc_pkg::CFG_HEIGHT, 24'(h));
		write_reg(gfc_pkg::CFG_BG, bg);
		write_reg(gfc_pkg::CFG_GMAP, 24'(gmap));
	endtask

	task automatic test_palette_load();
		req_t r;
		for (int i = 0; i < gfc_pkg::PALETTE_DEPTH; i++) begin
			r = mk(gfc_pkg::REQ_PALETTE);
			r.idx = 8'(i);
			if (i == 0) r.rgb = 24'h000000;
			if (i == 255) r.rgb = 24'hFFFFFF;
			send(r);
		end
	endtask

	task automatic test_directed();
		// Before any frame start, pixels are dropped and only off-canvas reads are legal.
		send_raster(1);
		send_read(16'hFFFF, 16'hFFFF);
		set_canvas(9'd8, 9'd8, 24'h123456, 1'b1);
		send(mk_frame(0, 0, 8, 8, 1'b0, 8'd0, 3'd0, 1'b1, 1'b0, 1'b1));
		send_read(7, 7);
		send(mk_frame(2, 2, 3, 3, 1'b1, 8'd5, gfc_pkg::DISP_BACKGROUND, 1'b0, 1'b1, 1'b1));
		send_raster(11);
		send_read(3, 3);
		send(mk_frame(6, 6, 4, 4, 1'b0, 8'd0, gfc_pkg::DISP_PREVIOUS, 1'b0, 1'b1, 1'b1));
		send_raster(16);
		send_read(7, 7);
		// Opaque frame that covers the previous one: no disposal.
		send(mk_frame(0, 0, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 3'd1, 1'b0, 1'b0, 1'b0));
		send_raster(3);
		send_read(8, 0);
		send_read(0, 0);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < 30; i++) send_read($urandom_range(0, 9), $urandom_range(0, 9));
		join
	endtask

	task automatic run_phase(int ph);
		int unsigned cw, ch, l, t, w, h, frames;
		logic [8:0]  pw, ph_;
		req_t        r;
		case (ph)
			1: begin pw = 9'd0; ph_ = 9'($urandom_range(1, 5)); end
			2: begin pw = 9'($urandom_range(257, 511)); ph_ = 9'd2; end
			3: begin pw = 9'd256; ph_ = 9'd256; end
			4: begin pw = 9'd1; ph_ = 9'($urandom_range(257, 511)); end
			default: begin
				pw = 9'($urandom_range(1, 24));
				ph_ = 9'($urandom_range(1, 24));
			end
		endcase
		set_canvas(pw, ph_, 24'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)));
		cw = canvas_w();
		ch = canvas_h();
		frames = (ph == 3) ? 3 : $urandom_range(2, 6);
		for (int f = 0; f < frames; f++) begin
			if ($urandom_range(0, 7) == 0) l = $urandom_range(0, 65535);
			else l = $urandom_range(0, cw + 1);
			if ($urandom_range(0, 7) == 0) t = $urandom_range(0, 65535);
			else t = $urandom_range(0, ch + 1);
			if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 65535);
			else w = $urandom_range(0, 6);
			if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 65535);
			else h = $urandom_range(0, 6);
			if (f > 0 && $urandom_range(0, 4) == 0) begin
				l = (prv_l > 0) ? prv_l - 1 : 0;
				t = prv_t;
				w = prv_w + 2;
				h = prv_h;
			end
			r = mk_frame(l, t, w, h, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				3'($urandom_range(0, 7)), f == 0, 1'($urandom_range(0, 1)),
				$urandom_range(0, 9) != 0);
			if (ph == 3 && f != 1 && r.disp == gfc_pkg::DISP_PREVIOUS)
				r.disp = gfc_pkg::DISP_BACKGROUND;
			send(r);
			send_raster(int'((32'(r.w) * 32'(r.h) > 24) ? 24 : 32'(r.w) * 32'(r.h)) +
				int'($urandom_range(0, 2)));
			for (int i = $urandom_range(1, 5); i > 0; i--) begin
				if ($urandom_range(0, 9) == 0) send(mk(gfc_pkg::REQ_READ));
				else if ($urandom_range(0, 5) == 0) send(mk(gfc_pkg::REQ_PALETTE));
				else send_read($urandom_range(0, cw - 1), $urandom_range(0, ch - 1));
			end
		end
	endtask

	task automatic test_random();
		int ph;
		ph = 1;
		while (n_sent < 860) begin
			if (n_sent > 760) calm = 1;
			run_phase(ph);
			ph++;
		end
	endtask

	// Receiver with random stall bursts.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if (hold_rx) pop <= 1'b0;
			else if (!calm && idle > 0) begin
				pop <= 1'b0;
				idle--;
			end else begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) idle = $urandom_range(1, 4);
			end
		end
	end

	always @(posedge clk) begin
		pix_t e;
		if (arst_n && pop && !empty) begin
			if (pending_pix.size() == 0) begin
				$error("unexpected result beat argb=%h valid=%b", pixel_argb, pixel_valid);
				fails++;
			end else begin
				e = pending_pix.pop_front();
				if (pixel_argb !== e.argb) begin
					$error("pixel_argb expected %h actual %h", e.argb, pixel_argb);
					fails++;
				end
				if (pixel_valid !== e.valid) begin
					$error("pixel_valid expected %b actual %b", e.valid, pixel_valid);
					fails++;
				end
			end
		end
	end

	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_load();
		test_directed();
		test_backpressure();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
